// File: rtl/ism_pkg.sv
`timescale 1ns / 1ps
package ism_pkg;

  localparam int VW = 48;

  typedef logic signed [VW-1:0] val_t;

  // Material item as it travels from the front part to the back part.
  typedef struct packed {
    logic [VW-1:0] first_value;
    logic [VW-1:0] second_value;
    logic          bulk_shear_form;
    logic [1:0]    dimensions;
    logic          stress_form;
    logic          halve_shear;
  } item_t;

  localparam logic [1:0] DIM_1D   = 2'd0;
  localparam logic [1:0] DIM_2D   = 2'd1;
  localparam logic [1:0] DIM_3D   = 2'd2;
  localparam logic [1:0] DIM_NONE = 2'd3;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // Clamp a wider signed value into the value format.
  function automatic logic signed [VW-1:0] sat52(input logic signed [51:0] v);
    logic signed [VW-1:0] r;
    begin
      if (v > 52'sh7FFFFFFFFFFF) r = VMAX;
      else if (v < -52'sh800000000000) r = VMIN;
      else r = v[VW-1:0];
      return r;
    end
  endfunction

endpackage

// File: rtl/ism_front.sv
`timescale 1ns / 1ps
module ism_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  ism_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_take,
  output ism_pkg::item_t q_item
);
  import ism_pkg::*;

  localparam int DEPTH = 2;

  item_t     mem_r [DEPTH];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      wr, rd;

  // Items with the unused dimension code produce nothing: drop them here.
  assign in_full = (cnt_r == 2'(DEPTH));
  assign wr      = in_push && !in_full && (in_item.dimensions != DIM_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign rd      = q_valid && q_take;
  assign q_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_item;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(DEPTH))
    else $error("front queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_item.dimensions == DIM_NONE && !rd) |=> $stable(cnt_r))
    else $error("dropped item changed queue count");

endmodule

// File: rtl/ism_back.sv
`timescale 1ns / 1ps
module ism_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [46:0]                  tol,
  input  logic                         q_valid,
  output logic                         q_take,
  input  ism_pkg::item_t               q_item,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [2:0]                   out_row,
  output logic [2:0]                   out_column,
  output logic signed [47:0]           out_entry_value,
  output logic                         out_saturated,
  output logic                         out_last
);
  import ism_pkg::*;

  localparam logic signed [VW-1:0] ONE  = VW'(64'd1 << FRACTION_BITS);
  localparam logic signed [VW-1:0] HALF = VW'(64'd1 << (FRACTION_BITS - 1));
  localparam int DIVN = 64 + FRACTION_BITS;  // quotient bits computed

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BS0  = 4'd1;
  localparam logic [3:0] S_BS1  = 4'd2;
  localparam logic [3:0] S_BS2  = 4'd3;
  localparam logic [3:0] S_BS3  = 4'd4;
  localparam logic [3:0] S_P0   = 4'd5;
  localparam logic [3:0] S_P1   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_P3   = 4'd8;
  localparam logic [3:0] S_P4   = 4'd9;
  localparam logic [3:0] S_P5   = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;
  localparam logic [3:0] S_WMUL = 4'd12;
  localparam logic [3:0] S_WDIV = 4'd13;

  logic [3:0] st_r, ret_r;
  item_t      it_r;
  val_t       e_r, nu_r, s_r, a_r, b_r, d_r, t_r, k_r;
  logic       flag_r, zs_r;

  // Shared multiplier: 48x48 magnitude product from four 24x24 partial products.
  logic        mul_go, mul_busy_r;
  val_t        mul_a, mul_b;
  logic [47:0] ma_r, mb_r;
  logic        mneg_r;
  logic [1:0]  mph_r;
  logic [95:0] macc_r;
  logic [23:0] ma_part, mb_part;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  val_t        mul_res;
  logic [95:0] mq;
  logic [47:0] mlim;

  always_comb begin
    ma_part = mph_r[1] ? ma_r[47:24] : ma_r[23:0];
    mb_part = mph_r[0] ? mb_r[47:24] : mb_r[23:0];
    pp      = 48'(ma_part) * 48'(mb_part);
    pp_sh   = 96'(pp) << (24 * (32'(mph_r[1]) + 32'(mph_r[0])));
    mq      = macc_r >> FRACTION_BITS;
    mlim    = mneg_r ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    if (mq[95:48] != '0 || mq[47:0] > mlim) mul_res = mneg_r ? VMIN : VMAX;
    else mul_res = mneg_r ? -val_t'(mq[47:0]) : val_t'(mq[47:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (mul_go) begin
      mul_busy_r <= 1'b1;
      mph_r      <= 2'd0;
      ma_r       <= mul_a[47] ? 48'(-mul_a) : 48'(mul_a);
      mb_r       <= mul_b[47] ? 48'(-mul_b) : 48'(mul_b);
      mneg_r     <= mul_a[47] != mul_b[47];
      macc_r     <= '0;
    end else if (mul_busy_r) begin
      macc_r <= macc_r + pp_sh;
      mph_r  <= mph_r + 2'd1;
      if (mph_r == 2'd3) mul_busy_r <= 1'b0;
    end
  end

  // ---- shared divider: restoring, one quotient bit a cycle ----
  logic        div_go, div_busy_r;
  val_t        div_n, div_d;
  logic [DIVN-1:0] dn_r;
  logic [48:0]     dr_r;
  logic [47:0]     dd_r;
  logic [63:0]     dq_r;
  logic            dbig_r, dneg_r, dz_r, dnn_r;
  logic [6:0]      dcnt_r;
  logic [48:0]     dr_sh;
  logic            dge;
  val_t            div_res;
  logic            div_ovf;
  logic [47:0]     dlim;
  logic [47:0]     dn_mag;

  always_comb begin
    dn_mag = div_n[47] ? 48'(-div_n) : 48'(div_n);
    dr_sh  = {dr_r[47:0], dn_r[DIVN-1]};
    dge    = dr_sh >= {1'b0, dd_r};
    dlim   = dneg_r ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    div_ovf = 1'b0;
    if (dz_r) begin
      div_res = dnn_r ? VMIN : VMAX;
      div_ovf = 1'b1;
    end else if (dbig_r || dq_r[63:48] != '0 || dq_r[47:0] > dlim) begin
      div_res = dneg_r ? VMIN : VMAX;
      div_ovf = 1'b1;
    end else begin
      div_res = dneg_r ? -val_t'(dq_r[47:0]) : val_t'(dq_r[47:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (div_go) begin
      div_busy_r <= (div_d != '0);
      dn_r   <= DIVN'(dn_mag) << FRACTION_BITS;
      dd_r   <= div_d[47] ? 48'(-div_d) : 48'(div_d);
      dr_r   <= '0;
      dq_r   <= '0;
      dbig_r <= 1'b0;
      dneg_r <= div_n[47] != div_d[47];
      dz_r   <= (div_d == '0);
      dnn_r  <= div_n[47];
      dcnt_r <= 7'(DIVN - 1);
    end else if (div_busy_r) begin
      dn_r <= dn_r << 1;
      if (dge) begin
        dr_r <= dr_sh - {1'b0, dd_r};
        if (dcnt_r >= 7'd63) dbig_r <= 1'b1;
        else dq_r[dcnt_r[5:0]] <= 1'b1;
      end else begin
        dr_r <= dr_sh;
      end
      if (dcnt_r == 7'd0) div_busy_r <= 1'b0;
      dcnt_r <= dcnt_r - 7'd1;
    end
  end

  // ---- output register ----
  logic       ov_r;
  logic [2:0] row_r, col_r, n_m1;
  logic       emit;

  assign out_empty = !ov_r;
  always_comb begin
    case (it_r.dimensions)
      DIM_1D:  n_m1 = 3'd0;
      DIM_2D:  n_m1 = 3'd2;
      default: n_m1 = 3'd5;
    endcase
  end

  // Matrix entry at (row_r, col_r).
  val_t ent;
  logic [2:0] nb;
  always_comb begin
    nb  = (it_r.dimensions == DIM_1D) ? 3'd1 : (it_r.dimensions == DIM_2D ? 3'd2 : 3'd3);
    ent = '0;
    if (zs_r) begin
      if (row_r < nb && col_r < nb) ent = k_r;
    end else if (it_r.dimensions == DIM_1D) begin
      ent = e_r;
    end else if (row_r < nb && col_r < nb) begin
      ent = (row_r == col_r) ? a_r : b_r;
    end else if (row_r == col_r) begin
      ent = d_r;
    end
  end

  assign emit   = (st_r == S_EMIT) && (!ov_r || out_pop);
  assign q_take = (st_r == S_IDLE) && q_valid;

  always_comb begin
    mul_go = 1'b0; div_go = 1'b0; mul_a = '0; mul_b = '0; div_n = '0; div_d = '0;
    case (st_r)
      S_BS0: begin
        mul_go = 1'b1; mul_a = k_r; mul_b = it_r.second_value;
      end
      S_BS1: begin
        div_go = 1'b1;
        div_n  = sat52(52'(t_r) * 52'sd9);
        div_d  = sat52(52'sd3 * 52'(k_r) + 52'(val_t'(it_r.second_value)));
      end
      S_BS2: begin
        div_go = 1'b1;
        div_n = sat52(52'sd3 * 52'(k_r) - 52'sd2 * 52'(val_t'(it_r.second_value)));
        div_d = sat52(52'sd6 * 52'(k_r) + 52'sd2 * 52'(val_t'(it_r.second_value)));
      end
      S_P0: begin
        mul_go = 1'b1;
        if (it_r.stress_form && it_r.dimensions == DIM_2D) begin
          mul_a = nu_r; mul_b = nu_r;
        end else begin
          mul_a = sat52(52'(ONE) + 52'(nu_r));
          mul_b = sat52(52'(ONE) - 52'sd2 * 52'(nu_r));
        end
      end
      S_P1: begin
        div_go = 1'b1; div_n = e_r;
        if (it_r.stress_form && it_r.dimensions == DIM_2D)
          div_d = sat52(52'(ONE) - 52'(t_r));
        else div_d = t_r;
      end
      S_P2: begin
        // s lands in s_r at this edge: take it straight from the divider
        mul_go = 1'b1; mul_b = div_res;
        if (it_r.stress_form && it_r.dimensions == DIM_2D) mul_a = ONE;
        else mul_a = sat52(52'(ONE) - 52'(nu_r));
      end
      S_P3: begin
        mul_go = 1'b1; mul_a = nu_r; mul_b = s_r;
      end
      S_P4: begin
        mul_go = 1'b1;
        if (it_r.dimensions == DIM_2D) begin
          mul_b = s_r;
          mul_a = it_r.stress_form ? sat52(52'(ONE) - 52'(nu_r))
                                   : sat52(52'(ONE) - 52'sd2 * 52'(nu_r));
        end else if (it_r.halve_shear) begin
          mul_a = sat52(52'(HALF) - 52'(nu_r)); mul_b = HALF;
        end else begin
          mul_a = sat52(52'(HALF) - 52'(nu_r)); mul_b = s_r;
        end
      end
      S_P5: begin
        mul_go = 1'b1; mul_a = t_r; mul_b = s_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      ret_r  <= S_IDLE;
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          it_r   <= q_item;
          k_r    <= q_item.first_value;
          e_r    <= q_item.first_value;
          nu_r   <= q_item.second_value;
          flag_r <= 1'b0;
          row_r  <= 3'd0;
          col_r  <= 3'd0;
          zs_r   <= q_item.bulk_shear_form && !q_item.halve_shear &&
                    ($signed(q_item.second_value) < $signed({1'b0, tol}));
          if (q_item.bulk_shear_form && !q_item.halve_shear &&
              ($signed(q_item.second_value) < $signed({1'b0, tol})))
            st_r <= S_EMIT;
          else if (q_item.dimensions == DIM_1D && !q_item.bulk_shear_form)
            st_r <= S_EMIT;
          else if (q_item.bulk_shear_form) st_r <= S_BS0;
          else st_r <= S_P0;
        end
        S_BS0: begin st_r <= S_WMUL; ret_r <= S_BS1; end
        S_BS1: begin st_r <= S_WDIV; ret_r <= S_BS2; end
        S_BS2: begin
          e_r <= div_res; flag_r <= flag_r | div_ovf;
          st_r <= S_WDIV; ret_r <= S_BS3;
        end
        S_BS3: begin
          nu_r <= div_res; flag_r <= flag_r | div_ovf;
          st_r <= (it_r.dimensions == DIM_1D) ? S_EMIT : S_P0;
        end
        S_P0: begin st_r <= S_WMUL; ret_r <= S_P1; end
        S_P1: begin st_r <= S_WDIV; ret_r <= S_P2; end
        S_P2: begin
          s_r <= div_res; flag_r <= flag_r | div_ovf;
          st_r <= S_WMUL; ret_r <= S_P3;
        end
        S_P3: begin a_r <= mul_res; st_r <= S_WMUL; ret_r <= S_P4; end
        S_P4: begin
          b_r <= mul_res; st_r <= S_WMUL;
          ret_r <= (it_r.dimensions == DIM_3D && it_r.halve_shear) ? S_P5 : S_EMIT;
        end
        S_P5: begin t_r <= mul_res; st_r <= S_WMUL; ret_r <= S_EMIT; end
        S_WMUL: if (!mul_busy_r && !mul_go) begin
          st_r <= ret_r;
          if (ret_r == S_BS1 || ret_r == S_P1 || ret_r == S_P5) t_r <= mul_res;
          if (ret_r == S_P3) s_r <= s_r;
          if (ret_r == S_EMIT) d_r <= mul_res;
        end
        S_WDIV: if (!div_busy_r && !div_go) st_r <= ret_r;
        S_EMIT: if (emit) begin
          out_row         <= row_r;
          out_column      <= col_r;
          out_saturated   <= flag_r;
          out_last        <= (row_r == n_m1) && (col_r == n_m1);
          // 2D shear entry rides in d; plane-stress diagonal a is ONE*s
          out_entry_value <= (!zs_r && it_r.dimensions == DIM_2D &&
                              row_r == 3'd2 && col_r == 3'd2) ? d_r : ent;
          if (col_r == n_m1) begin
            col_r <= 3'd0;
            row_r <= row_r + 3'd1;
            if (row_r == n_m1) st_r <= S_IDLE;
          end else begin
            col_r <= col_r + 3'd1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // a_r holds the product from S_P2, captured when the wait returns to S_P3.
  // (S_P3 launches nu*s; its result lands in b_r at S_P4.)
  // Note ordering: S_P3 stores mul_res (a); S_P4 stores mul_res (b).

  assert property (@(posedge clk) disable iff (!rst_n) !(mul_busy_r && mul_go))
    else $error("multiplier restarted while busy");
  assert property (@(posedge clk) disable iff (!rst_n) !(div_busy_r && div_go))
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_pop) |=> (ov_r && $stable(out_entry_value)))
    else $error("held beat changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == S_IDLE)
    else $error("item taken while busy");

endmodule

// File: rtl/isotropic_stiffness_matrix.sv
`timescale 1ns / 1ps
// Isotropic linear-elastic stiffness matrix generator.
// Input channel (in_push / in_full): one beat carries a material pair, either
// Young's modulus and Poisson ratio or bulk and shear modulus, plus the
// dimension code and formula flags. A two-entry queue in the front part takes
// beats while the back part is still busy; beats with dimension code three
// are dropped there and give no result.
// Result channel (out_empty / out_pop): one beat per matrix entry in row-major
// order, 1, 9 or 36 beats per item, out_last on the final one. An output
// register holds the beat while the receiver stalls; the back part freezes.
// Set-up runs on one shared multiplier (launch, four partial products,
// hand-back) and one shared divider that retires one quotient bit a cycle.
// A Young/Poisson 2D or 3D item takes four multiplies (five with halve_shear
// in 3D) and one divide after leaving the queue, before its first beat.
// A bulk/shear item adds one multiply and two divides. A 1D Young item and
// the zero-shear case skip set-up. Entries then stream at one beat a cycle
// while the receiver takes them; the next item leaves the queue only after
// the final beat of the current one.
// Configuration: APB write to address 0 sets zero_shear_tolerance (64-bit
// data, register 0 at byte 0). Reset clears the queues, state and sets the
// tolerance to one LSB.
module isotropic_stiffness_matrix #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [47:0]  in_first_value,
  input  logic signed [47:0]  in_second_value,
  input  logic                in_bulk_shear_form,
  input  logic [1:0]          in_dimensions,
  input  logic                in_stress_form,
  input  logic                in_halve_shear,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_row,
  output logic [2:0]          out_column,
  output logic signed [47:0]  out_entry_value,
  output logic                out_saturated,
  output logic                out_last,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_paddr,
  input  logic [63:0]         cfg_pwdata,
  output logic [63:0]         cfg_prdata,
  output logic                cfg_pready
);
  import ism_pkg::*;

  logic [46:0] tol_r;
  item_t       in_item, q_item;
  logic        q_valid, q_take;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr ? 64'd0 : 64'(tol_r);

  // Register write on the access beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 47'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) begin
      tol_r <= cfg_pwdata[46:0];
    end
  end

  assign in_item = '{first_value: in_first_value, second_value: in_second_value,
                     bulk_shear_form: in_bulk_shear_form, dimensions: in_dimensions,
                     stress_form: in_stress_form, halve_shear: in_halve_shear};

  ism_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .q_valid, .q_take, .q_item
  );

  ism_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .tol(tol_r), .q_valid, .q_take, .q_item,
    .out_empty, .out_pop, .out_row, .out_column, .out_entry_value,
    .out_saturated, .out_last
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) |=> tol_r == $past(cfg_pwdata[46:0]))
    else $error("tolerance write lost");
  assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("stalled beat vanished");

endmodule
